// File: rtl/core/rotation_matrix_to_quaternion_defines.svh
// assertion macros shared by the rotation matrix to quaternion rtl
// both expect clk and arst_n in scope
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`ifndef SYNTHESIS
`define RMQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define RMQ_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define RMQ_ASSERT(lbl, prop, msg)
`define RMQ_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: rtl/core/rmq_pkg.sv
package rmq_pkg;

	localparam int FRAC_BITS_DEF = 14;
	localparam int ELEM_W = 16;
	// sum or difference of two elements
	localparam int DIFF_W = 17;
	// quotient bits of the quarter division
	localparam int QUOT_W = 17;
	localparam int QUEUE_DEPTH = 2;

	// pivot case codes
	localparam logic [1:0] PIV_W = 2'd0;
	localparam logic [1:0] PIV_X = 2'd1;
	localparam logic [1:0] PIV_Y = 2'd2;
	localparam logic [1:0] PIV_Z = 2'd3;

	typedef logic signed [ELEM_W-1:0] elem_t;

	typedef struct packed {
		elem_t r11;
		elem_t r12;
		elem_t r13;
		elem_t r21;
		elem_t r22;
		elem_t r23;
		elem_t r31;
		elem_t r32;
		elem_t r33;
	} mat_t;

	typedef struct packed {
		elem_t quat_w;
		elem_t quat_x;
		elem_t quat_y;
		elem_t quat_z;
		logic [1:0] pivot_case;
	} quat_t;

	// three off-diagonal numerators, non-pivot components in ascending order
	typedef logic [2:0][DIFF_W-1:0] diff_arr_t;

	// signed width of a trace term
	function automatic int trace_w(input int frac);
		int w;
		w = (frac > DIFF_W) ? frac : DIFF_W;
		return w + 3;
	endfunction

endpackage

// File: rtl/core/rmq_front.sv
module rmq_front #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
	parameter int TU = rmq_pkg::trace_w(rmq_pkg::FRAC_BITS_DEF) - 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               mat_valid,
	output logic               mat_ready,
	input  rmq_pkg::mat_t      mat,
	output logic               item_valid,
	input  logic               item_ready,
	output logic [TU-1:0]      item_tmax,
	output rmq_pkg::diff_arr_t item_diff,
	output logic [1:0]         item_case
);

	localparam int TW = TU + 1;
	localparam int DW = rmq_pkg::DIFF_W;
	localparam logic signed [TW-1:0] ONE = TW'(1) << FRAC_BITS;

	logic signed [TW-1:0] e11, e22, e33;
	logic signed [TW-1:0] t0, t1, t2, t3, tk;
	logic [1:0] k;
	logic signed [DW-1:0] d23m, d31m, d12m, d12p, d13p, d23p;
	rmq_pkg::diff_arr_t diff;

	logic v_s1;
	logic [TU-1:0] tmax_s1;
	rmq_pkg::diff_arr_t diff_s1;
	logic [1:0] case_s1;

	// trace terms
	assign e11 = TW'(mat.r11);
	assign e22 = TW'(mat.r22);
	assign e33 = TW'(mat.r33);
	assign t0 = ONE + e11 + e22 + e33;
	assign t1 = ONE + e11 - e22 - e33;
	assign t2 = ONE - e11 + e22 - e33;
	assign t3 = ONE - e11 - e22 + e33;

	// largest term, lowest index on a tie
	always_comb begin
		k = rmq_pkg::PIV_W;
		tk = t0;
		if (t1 > tk) begin
			k = rmq_pkg::PIV_X;
			tk = t1;
		end
		if (t2 > tk) begin
			k = rmq_pkg::PIV_Y;
			tk = t2;
		end
		if (t3 > tk) begin
			k = rmq_pkg::PIV_Z;
			tk = t3;
		end
	end

	// off-diagonal numerators
	assign d23m = DW'(mat.r23) - DW'(mat.r32);
	assign d31m = DW'(mat.r31) - DW'(mat.r13);
	assign d12m = DW'(mat.r12) - DW'(mat.r21);
	assign d12p = DW'(mat.r12) + DW'(mat.r21);
	assign d13p = DW'(mat.r13) + DW'(mat.r31);
	assign d23p = DW'(mat.r23) + DW'(mat.r32);

	always_comb begin
		case (k)
			rmq_pkg::PIV_W: diff = {d12m, d31m, d23m};
			rmq_pkg::PIV_X: diff = {d13p, d12p, d23m};
			rmq_pkg::PIV_Y: diff = {d23p, d12p, d31m};
			default:        diff = {d23p, d13p, d12m};
		endcase
	end

	// stage register
	assign mat_ready = !v_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (mat_ready) begin
			v_s1 <= mat_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (mat_ready && mat_valid) begin
			tmax_s1 <= tk[TU-1:0];
			diff_s1 <= diff;
			case_s1 <= k;
		end
	end

	assign item_valid = v_s1;
	assign item_tmax = tmax_s1;
	assign item_diff = diff_s1;
	assign item_case = case_s1;

endmodule

// File: rtl/core/rmq_queue.sv
`include "rotation_matrix_to_quaternion_defines.svh"

module rmq_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = rmq_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;
	logic push, pop;

	assign wr_ready = (cnt_q != CW'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;
	assign rd_data = mem_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`RMQ_ASSERT_NEVER(a_cnt_range, cnt_q > CW'(DEPTH), "queue count beyond depth")
	`RMQ_ASSERT(a_cnt_up, push && !pop |=> cnt_q == $past(cnt_q) + 1'b1, "queue count missed push")
	`RMQ_ASSERT(a_cnt_dn, pop && !push |=> cnt_q == $past(cnt_q) - 1'b1, "queue count missed pop")

endmodule

// File: rtl/core/rmq_back.sv
`include "rotation_matrix_to_quaternion_defines.svh"

module rmq_back #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
	parameter int TU = rmq_pkg::trace_w(rmq_pkg::FRAC_BITS_DEF) - 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [TU-1:0]      item_tmax,
	input  rmq_pkg::diff_arr_t item_diff,
	input  logic [1:0]         item_case,
	output logic               quat_valid,
	input  logic               quat_ready,
	output rmq_pkg::quat_t     quat
);

	localparam int SW = (TU + FRAC_BITS + 1) / 2;
	localparam int VW = 2 * SW;
	localparam int RW = SW + 3;
	localparam int DW = SW + 2;
	localparam int QB = rmq_pkg::QUOT_W;
	localparam int XW = rmq_pkg::DIFF_W;
	localparam int NW = ((XW + FRAC_BITS > SW + 1) ? XW + FRAC_BITS : SW + 1) + 1;
	localparam int SATV = (FRAC_BITS < 15) ? (1 << FRAC_BITS) : 32767;
	localparam logic [SW-1:0] SATP = SW'(SATV);
	localparam logic signed [QB:0] SATQ = (QB + 1)'(SATV);

	logic adv;

	// square root pipeline, two radicand bits per stage
	logic [SW:0] sv;
	logic [VW-1:0] srad [0:SW];
	logic [RW-1:0] srem [0:SW];
	logic [SW-1:0] sroot [0:SW];
	rmq_pkg::diff_arr_t sdiff [0:SW];
	logic [1:0] scase [0:SW];

	// quarter division pipeline, one quotient bit per stage and lane
	logic [QB:0] dv;
	logic [DW-1:0] dden [0:QB];
	logic [SW-1:0] dp [0:QB];
	logic [2:0][DW-1:0] drem [0:QB];
	logic [2:0][QB-1:0] dnum [0:QB];
	logic [2:0][QB-1:0] dq [0:QB];
	logic [2:0] dneg [0:QB];
	logic [1:0] dcase [0:QB];

	logic quat_valid_q;
	rmq_pkg::quat_t quat_q;

	// the whole back end moves together, held while a result waits
	assign adv = !quat_valid_q || quat_ready;
	assign item_ready = adv;

	assign sv[0] = item_valid;
	assign srad[0] = VW'({item_tmax, {FRAC_BITS{1'b0}}});
	assign srem[0] = '0;
	assign sroot[0] = '0;
	assign sdiff[0] = item_diff;
	assign scase[0] = item_case;

	for (genvar i = 0; i < SW; i++) begin : g_sqrt
		logic [RW-1:0] remx, trial;
		logic ge;

		// trial subtract of 4*root+1
		assign remx = {srem[i][RW-3:0], srad[i][VW-1 -: 2]};
		assign trial = RW'({sroot[i], 2'b01});
		assign ge = (remx >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv[i+1] <= 1'b0;
			end else if (adv) begin
				sv[i+1] <= sv[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				srem[i+1] <= ge ? remx - trial : remx;
				sroot[i+1] <= {sroot[i][SW-2:0], ge};
				srad[i+1] <= srad[i] << 2;
				sdiff[i+1] <= sdiff[i];
				scase[i+1] <= scase[i];
			end
		end
	end

	// pivot rounding and division setup
	logic [SW:0] pw;
	logic [SW-1:0] pval;
	logic [2:0][DW-1:0] rem0;
	logic [2:0][QB-1:0] num0;
	logic [2:0] neg0;

	assign pw = {1'b0, sroot[SW]} + 1'b1;
	assign pval = pw[SW:1];

	for (genvar l = 0; l < 3; l++) begin : g_prep
		logic [XW-1:0] mag;
		logic [NW-1:0] nsum, nsh;

		assign neg0[l] = sdiff[SW][l][XW-1];
		assign mag = neg0[l] ? -sdiff[SW][l] : sdiff[SW][l];
		// numerator plus half the divisor for rounding
		assign nsum = NW'({mag, {FRAC_BITS{1'b0}}}) + NW'({pval, 1'b0});
		assign nsh = nsum >> QB;
		assign rem0[l] = nsh[DW-1:0];
		assign num0[l] = nsum[QB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv[0] <= 1'b0;
		end else if (adv) begin
			dv[0] <= sv[SW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dden[0] <= DW'({pval, 2'b00});
			dp[0] <= pval;
			drem[0] <= rem0;
			dnum[0] <= num0;
			dq[0] <= '0;
			dneg[0] <= neg0;
			dcase[0] <= scase[SW];
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_div
		logic [2:0][DW-1:0] rem_nx;
		logic [2:0] ge;

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [DW:0] r2, sub;

			assign r2 = {drem[j][l], dnum[j][l][QB-1]};
			assign sub = r2 - {1'b0, dden[j]};
			assign ge[l] = (r2 >= {1'b0, dden[j]});
			assign rem_nx[l] = ge[l] ? sub[DW-1:0] : r2[DW-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv[j+1] <= 1'b0;
			end else if (adv) begin
				dv[j+1] <= dv[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int l = 0; l < 3; l++) begin
					drem[j+1][l] <= rem_nx[l];
					dnum[j+1][l] <= dnum[j][l] << 1;
					dq[j+1][l] <= {dq[j][l][QB-2:0], ge[l]};
				end
				dden[j+1] <= dden[j];
				dp[j+1] <= dp[j];
				dneg[j+1] <= dneg[j];
				dcase[j+1] <= dcase[j];
			end
		end
	end

	// sign and saturation
	logic [2:0][15:0] lane_sat;
	logic [15:0] piv_sat;

	for (genvar l = 0; l < 3; l++) begin : g_sat
		logic signed [QB:0] qs;

		assign qs = dneg[QB][l] ? -$signed({1'b0, dq[QB][l]}) : $signed({1'b0, dq[QB][l]});
		assign lane_sat[l] = (qs > SATQ) ? SATQ[15:0] :
			(qs < -SATQ) ? 16'(-SATQ) : qs[15:0];
	end

	assign piv_sat = (dp[QB] > SATP) ? SATP[15:0] : dp[QB][15:0];

	// place the pivot and the three lanes
	rmq_pkg::quat_t asm_q;

	always_comb begin
		asm_q.pivot_case = dcase[QB];
		case (dcase[QB])
			rmq_pkg::PIV_W: begin
				asm_q.quat_w = piv_sat;
				asm_q.quat_x = lane_sat[0];
				asm_q.quat_y = lane_sat[1];
				asm_q.quat_z = lane_sat[2];
			end
			rmq_pkg::PIV_X: begin
				asm_q.quat_w = lane_sat[0];
				asm_q.quat_x = piv_sat;
				asm_q.quat_y = lane_sat[1];
				asm_q.quat_z = lane_sat[2];
			end
			rmq_pkg::PIV_Y: begin
				asm_q.quat_w = lane_sat[0];
				asm_q.quat_x = lane_sat[1];
				asm_q.quat_y = piv_sat;
				asm_q.quat_z = lane_sat[2];
			end
			default: begin
				asm_q.quat_w = lane_sat[0];
				asm_q.quat_x = lane_sat[1];
				asm_q.quat_y = lane_sat[2];
				asm_q.quat_z = piv_sat;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_valid_q <= 1'b0;
		end else if (adv) begin
			quat_valid_q <= dv[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			quat_q <= asm_q;
		end
	end

	assign quat_valid = quat_valid_q;
	assign quat = quat_q;

	`RMQ_ASSERT(a_piv_pos, quat_valid_q |-> (quat_q.pivot_case != rmq_pkg::PIV_W || !quat_q.quat_w[15]) && (quat_q.pivot_case != rmq_pkg::PIV_X || !quat_q.quat_x[15]) && (quat_q.pivot_case != rmq_pkg::PIV_Y || !quat_q.quat_y[15]) && (quat_q.pivot_case != rmq_pkg::PIV_Z || !quat_q.quat_z[15]), "pivot component negative")
	`RMQ_ASSERT(a_out_src, $rose(quat_valid_q) |-> $past(dv[QB]), "result without pipeline source")
	`RMQ_ASSERT(a_freeze, quat_valid_q && !quat_ready |=> $stable(dv), "pipeline moved during stall")

endmodule

// File: rtl/core/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion, pivoting on the largest trace term, in signed fixed point with
// FRAC_BITS fraction bits. One matrix request is taken per cycle and one
// quaternion with its pivot case comes out per cycle while quat_ready stays high;
// SW = (TU + FRAC_BITS + 1) / 2 is the number of square root stages. The depth is
// set by the digit-by-digit square root and the bit-per-stage restoring divider.
// A front stage forms the trace terms, picks the pivot and the off-diagonal
// numerators; a two-entry queue decouples it from the back end, which stalls
// as a whole only while a finished result is not taken. No reset sequence.
module rotation_matrix_to_quaternion #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           mat_valid,
	output logic           mat_ready,
	input  rmq_pkg::mat_t  mat,
	output logic           quat_valid,
	input  logic           quat_ready,
	output rmq_pkg::quat_t quat
);

	localparam int TU = rmq_pkg::trace_w(FRAC_BITS) - 1;
	localparam int XW = 3 * rmq_pkg::DIFF_W;
	localparam int QW = TU + XW + 2;

	logic f_valid, f_ready, b_valid, b_ready;
	logic [TU-1:0] f_tmax, b_tmax;
	rmq_pkg::diff_arr_t f_diff, b_diff;
	logic [1:0] f_case, b_case;
	logic [QW-1:0] b_data;

	rmq_front #(
		.FRAC_BITS(FRAC_BITS),
		.TU(TU)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.mat_valid(mat_valid),
		.mat_ready(mat_ready),
		.mat(mat),
		.item_valid(f_valid),
		.item_ready(f_ready),
		.item_tmax(f_tmax),
		.item_diff(f_diff),
		.item_case(f_case)
	);

	rmq_queue #(
		.WIDTH(QW),
		.DEPTH(rmq_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_valid(f_valid),
		.wr_ready(f_ready),
		.wr_data({f_tmax, f_diff, f_case}),
		.rd_valid(b_valid),
		.rd_ready(b_ready),
		.rd_data(b_data)
	);

	assign b_tmax = b_data[QW-1 -: TU];
	assign b_diff = b_data[XW+1:2];
	assign b_case = b_data[1:0];

	rmq_back #(
		.FRAC_BITS(FRAC_BITS),
		.TU(TU)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(b_valid),
		.item_ready(b_ready),
		.item_tmax(b_tmax),
		.item_diff(b_diff),
		.item_case(b_case),
		.quat_valid(quat_valid),
		.quat_ready(quat_ready),
		.quat(quat)
	);

endmodule
